// ----- hw/rtl/sdrt_pkg.sv -----
// Shared constants and operation codes for the surface dirty region tracker.
package sdrt_pkg;

    // Default sizes
    localparam int TARGET_SLOTS_DEF = 8;
    localparam int MARK_SLOTS_DEF   = 16;
    localparam int COORD_BITS_DEF   = 16;

    // Fixed field widths
    localparam int HANDLE_W = 32;
    localparam int KIND_W   = 3;
    localparam int REGION_W = 2;

    // Operation codes carried in the kind field
    localparam logic [KIND_W-1:0] KIND_REGISTER = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MARK     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CONSUME  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_REQUEUE  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_RESET    = 3'd6;

    // Consume answers
    localparam logic [REGION_W-1:0] REGION_NONE    = 2'd0;
    localparam logic [REGION_W-1:0] REGION_PARTIAL = 2'd1;
    localparam logic [REGION_W-1:0] REGION_WHOLE   = 2'd2;

endpackage

// ----- hw/rtl/sdrt_cmp.sv -----
// Shared identity compare unit used by both the target scan and the mark scan.
module sdrt_cmp (
    input  logic                          target_mode,
    input  logic [sdrt_pkg::HANDLE_W-1:0] item_handle,
    input  logic [sdrt_pkg::HANDLE_W-1:0] item_key,
    input  logic [sdrt_pkg::HANDLE_W-1:0] entry_handle,
    input  logic [sdrt_pkg::HANDLE_W-1:0] entry_key,
    output logic                          hit
);
    import sdrt_pkg::*;

    logic handle_eq;
    logic key_eq;
    logic key_nz;

    // Compare identities
    assign handle_eq = (item_handle == entry_handle);
    assign key_eq    = (item_key == entry_key);
    assign key_nz    = (item_key != '0);

    // Targets match on handle or on a known key; marks match on key alone
    assign hit = target_mode ? (handle_eq || (key_nz && key_eq)) : key_eq;

endmodule

// ----- hw/rtl/sdrt_rect_merge.sv -----
// Rectangle emptiness check and bounding-box union for one mark update.
module sdrt_rect_merge #(
    parameter int COORD_BITS = sdrt_pkg::COORD_BITS_DEF
) (
    input  logic signed [COORD_BITS-1:0] w_left,
    input  logic signed [COORD_BITS-1:0] w_top,
    input  logic signed [COORD_BITS-1:0] w_right,
    input  logic signed [COORD_BITS-1:0] w_bottom,
    input  logic                         m_valid,
    input  logic signed [COORD_BITS-1:0] m_left,
    input  logic signed [COORD_BITS-1:0] m_top,
    input  logic signed [COORD_BITS-1:0] m_right,
    input  logic signed [COORD_BITS-1:0] m_bottom,
    output logic                         w_empty,
    output logic signed [COORD_BITS-1:0] n_left,
    output logic signed [COORD_BITS-1:0] n_top,
    output logic signed [COORD_BITS-1:0] n_right,
    output logic signed [COORD_BITS-1:0] n_bottom
);

    // Flag an empty written rectangle
    assign w_empty = (w_right <= w_left) || (w_bottom <= w_top);

    // Grow the stored box; an empty stored box takes the write as is
    assign n_left   = (!m_valid || (w_left < m_left))     ? w_left   : m_left;
    assign n_top    = (!m_valid || (w_top < m_top))       ? w_top    : m_top;
    assign n_right  = (!m_valid || (w_right > m_right))   ? w_right  : m_right;
    assign n_bottom = (!m_valid || (w_bottom > m_bottom)) ? w_bottom : m_bottom;

endmodule

// ----- hw/rtl/surface_dirty_region_tracker.sv -----
// Top level of the surface dirty region tracker: sequencer, slot storage, result register.
// Each beat on the input channel is one operation chosen by kind. The block takes a beat
// only while idle, then walks its slots through a single shared compare unit, one slot per
// cycle: register and mark write visit all TARGET_SLOTS target entries, and mark write,
// query, consume, clear and requeue visit all MARK_SLOTS marks. An apply state then
// applies the operation and loads the result register, and the block returns to idle to
// take the next beat; reset and the unused kind go straight to the apply state. The result
// register decouples the channels, so a new beat is taken while the previous result waits;
// the apply cycle holds only while that result is still unread.
// Reset state is held in per-slot flags, so no clearing pass is needed after reset.
module surface_dirty_region_tracker #(
    parameter int TARGET_SLOTS = sdrt_pkg::TARGET_SLOTS_DEF,
    parameter int MARK_SLOTS   = sdrt_pkg::MARK_SLOTS_DEF,
    parameter int COORD_BITS   = sdrt_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sdrt_pkg::KIND_W-1:0]   s_kind,
    input  logic [sdrt_pkg::HANDLE_W-1:0] s_surface_handle,
    input  logic [sdrt_pkg::HANDLE_W-1:0] s_surface_key,
    input  logic                          s_capture_busy,
    input  logic                          s_rect_exact,
    input  logic signed [COORD_BITS-1:0]  s_wr_left,
    input  logic signed [COORD_BITS-1:0]  s_wr_top,
    input  logic signed [COORD_BITS-1:0]  s_wr_right,
    input  logic signed [COORD_BITS-1:0]  s_wr_bottom,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sdrt_pkg::REGION_W-1:0] m_region,
    output logic signed [COORD_BITS-1:0]  m_out_left,
    output logic signed [COORD_BITS-1:0]  m_out_top,
    output logic signed [COORD_BITS-1:0]  m_out_right,
    output logic signed [COORD_BITS-1:0]  m_out_bottom,
    output logic                          m_pending
);
    import sdrt_pkg::*;

    localparam int TIDX_W   = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
    localparam int MIDX_W   = (MARK_SLOTS > 1) ? $clog2(MARK_SLOTS) : 1;
    localparam int TCNT_W   = $clog2(TARGET_SLOTS + 1);
    localparam int SCAN_MAX = (TARGET_SLOTS > MARK_SLOTS) ? TARGET_SLOTS : MARK_SLOTS;
    localparam int SCAN_W   = (SCAN_MAX > 1) ? $clog2(SCAN_MAX) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_TSCAN = 2'd1;
    localparam logic [1:0] ST_MSCAN = 2'd2;
    localparam logic [1:0] ST_EXEC  = 2'd3;

    // Sequencer
    logic [1:0]        state_reg, state_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;

    // Latched beat
    logic [KIND_W-1:0]          kind_reg;
    logic [HANDLE_W-1:0]        handle_reg;
    logic [HANDLE_W-1:0]        key_reg;
    logic                       busy_reg;
    logic                       exact_reg;
    logic signed [COORD_BITS-1:0] wl_reg, wt_reg, wr_reg, wb_reg;

    // Scan results
    logic              thit_reg;
    logic              mhit_reg;
    logic              mfree_reg;
    logic [MIDX_W-1:0] midx_reg;
    logic [MIDX_W-1:0] fidx_reg;

    // Tracker state
    logic [TCNT_W-1:0]   tcount_reg;
    logic                track_reg;
    logic                ovf_reg;
    logic [HANDLE_W-1:0] target_handle_mem [TARGET_SLOTS];
    logic [HANDLE_W-1:0] target_key_mem    [TARGET_SLOTS];
    logic [HANDLE_W-1:0] mark_key_mem      [MARK_SLOTS];
    logic signed [COORD_BITS-1:0] mark_l_mem [MARK_SLOTS];
    logic signed [COORD_BITS-1:0] mark_t_mem [MARK_SLOTS];
    logic signed [COORD_BITS-1:0] mark_r_mem [MARK_SLOTS];
    logic signed [COORD_BITS-1:0] mark_b_mem [MARK_SLOTS];
    logic [MARK_SLOTS-1:0] mark_whole_reg;
    logic [MARK_SLOTS-1:0] mark_rv_reg;

    // Result register
    logic                  m_valid_reg;
    logic [REGION_W-1:0]   m_region_reg;
    logic signed [COORD_BITS-1:0] m_l_reg, m_t_reg, m_r_reg, m_b_reg;
    logic                  m_pending_reg;

    logic              accept;
    logic              out_free;
    logic              exec_fire;
    logic [TIDX_W-1:0] tidx;
    logic [MIDX_W-1:0] midx_s;
    logic [HANDLE_W-1:0] entry_key;
    logic              cmp_hit;
    logic              t_live;
    logic              m_used_s;
    logic              scan_last;
    logic              handle_nz;
    logic [MIDX_W-1:0] slot;
    logic              slot_ok;
    logic              mw_go;
    logic              rq_go;
    logic              take_go;
    logic              reg_go;
    logic              t_full;
    logic              w_empty;
    logic signed [COORD_BITS-1:0] n_l, n_t, n_r, n_b;
    logic [REGION_W-1:0] res_region;
    logic signed [COORD_BITS-1:0] res_l, res_t, res_r, res_b;
    logic                res_pending;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign exec_fire = (state_reg == ST_EXEC) && out_free;

    // Select the slot under scan
    assign tidx     = scan_reg[TIDX_W-1:0];
    assign midx_s   = scan_reg[MIDX_W-1:0];
    assign entry_key = (state_reg == ST_TSCAN) ? target_key_mem[tidx] : mark_key_mem[midx_s];
    assign t_live   = (32'(scan_reg) < 32'(tcount_reg));
    assign m_used_s = mark_whole_reg[midx_s] | mark_rv_reg[midx_s];
    assign scan_last = (state_reg == ST_TSCAN) ? (scan_reg == SCAN_W'(TARGET_SLOTS - 1))
                                               : (scan_reg == SCAN_W'(MARK_SLOTS - 1));

    sdrt_cmp u_cmp (
        .target_mode  (state_reg == ST_TSCAN),
        .item_handle  (handle_reg),
        .item_key     (key_reg),
        .entry_handle (target_handle_mem[tidx]),
        .entry_key    (entry_key),
        .hit          (cmp_hit)
    );

    // Decide the operation's effect
    assign handle_nz = (handle_reg != '0);
    assign slot      = mhit_reg ? midx_reg : fidx_reg;
    assign slot_ok   = mhit_reg || mfree_reg;
    assign mw_go     = (kind_reg == KIND_MARK) && handle_nz && !busy_reg &&
                       (track_reg || thit_reg);
    assign rq_go     = (kind_reg == KIND_REQUEUE) && handle_nz;
    assign take_go   = mw_go || rq_go;
    assign reg_go    = (kind_reg == KIND_REGISTER) && handle_nz && !track_reg && !thit_reg;
    assign t_full    = (32'(tcount_reg) >= TARGET_SLOTS);

    sdrt_rect_merge #(
        .COORD_BITS (COORD_BITS)
    ) u_merge (
        .w_left   (wl_reg),
        .w_top    (wt_reg),
        .w_right  (wr_reg),
        .w_bottom (wb_reg),
        .m_valid  (mark_rv_reg[slot]),
        .m_left   (mark_l_mem[slot]),
        .m_top    (mark_t_mem[slot]),
        .m_right  (mark_r_mem[slot]),
        .m_bottom (mark_b_mem[slot]),
        .w_empty  (w_empty),
        .n_left   (n_l),
        .n_top    (n_t),
        .n_right  (n_r),
        .n_bottom (n_b)
    );

    // Build the result beat
    always_comb begin
        res_region  = REGION_NONE;
        res_l       = '0;
        res_t       = '0;
        res_r       = '0;
        res_b       = '0;
        res_pending = 1'b0;
        case (kind_reg)
            KIND_QUERY: begin
                res_pending = handle_nz && (ovf_reg || mhit_reg);
            end
            KIND_CONSUME: begin
                if (!handle_nz || ovf_reg) begin
                    res_region = REGION_WHOLE;
                end else if (mhit_reg) begin
                    res_region = mark_whole_reg[slot] ? REGION_WHOLE :
                                 (mark_rv_reg[slot] ? REGION_PARTIAL : REGION_NONE);
                    if (mark_rv_reg[slot]) begin
                        res_l = mark_l_mem[slot];
                        res_t = mark_t_mem[slot];
                        res_r = mark_r_mem[slot];
                        res_b = mark_b_mem[slot];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Advance the sequencer
    always_comb begin
        state_next = state_reg;
        scan_next  = scan_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    scan_next = '0;
                    if (s_kind == KIND_REGISTER || s_kind == KIND_MARK) begin
                        state_next = ST_TSCAN;
                    end else if (s_kind == KIND_QUERY || s_kind == KIND_CONSUME ||
                                 s_kind == KIND_CLEAR || s_kind == KIND_REQUEUE) begin
                        state_next = ST_MSCAN;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_TSCAN: begin
                if (scan_last) begin
                    scan_next  = '0;
                    state_next = (kind_reg == KIND_MARK) ? ST_MSCAN : ST_EXEC;
                end else begin
                    scan_next = scan_reg + SCAN_W'(1);
                end
            end
            ST_MSCAN: begin
                if (scan_last) begin
                    scan_next  = '0;
                    state_next = ST_EXEC;
                end else begin
                    scan_next = scan_reg + SCAN_W'(1);
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Update control state and slot flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            scan_reg       <= '0;
            thit_reg       <= 1'b0;
            mhit_reg       <= 1'b0;
            mfree_reg      <= 1'b0;
            tcount_reg     <= '0;
            track_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
            mark_whole_reg <= '0;
            mark_rv_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            // Load a new result beat, else drop the one taken by the receiver
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                thit_reg  <= 1'b0;
                mhit_reg  <= 1'b0;
                mfree_reg <= 1'b0;
            end
            if (state_reg == ST_TSCAN && t_live && cmp_hit) begin
                thit_reg <= 1'b1;
            end
            if (state_reg == ST_MSCAN) begin
                if (m_used_s && cmp_hit) begin
                    mhit_reg <= 1'b1;
                end
                if (!m_used_s) begin
                    mfree_reg <= 1'b1;
                end
            end
            if (exec_fire) begin
                case (kind_reg)
                    KIND_REGISTER: begin
                        if (reg_go) begin
                            if (t_full) begin
                                track_reg <= 1'b1;
                            end else begin
                                tcount_reg <= tcount_reg + TCNT_W'(1);
                            end
                        end
                    end
                    KIND_MARK, KIND_REQUEUE: begin
                        if (take_go) begin
                            if (!slot_ok) begin
                                ovf_reg <= 1'b1;
                            end else if (rq_go || !exact_reg) begin
                                mark_whole_reg[slot] <= 1'b1;
                            end else if (!w_empty) begin
                                mark_rv_reg[slot] <= 1'b1;
                            end
                        end
                    end
                    KIND_CONSUME: begin
                        if (handle_nz && !ovf_reg && mhit_reg) begin
                            mark_whole_reg[slot] <= 1'b0;
                            mark_rv_reg[slot]    <= 1'b0;
                        end
                    end
                    KIND_CLEAR: begin
                        if (handle_nz && mhit_reg) begin
                            mark_whole_reg[slot] <= 1'b0;
                            mark_rv_reg[slot]    <= 1'b0;
                        end
                    end
                    KIND_RESET: begin
                        tcount_reg     <= '0;
                        track_reg      <= 1'b0;
                        ovf_reg        <= 1'b0;
                        mark_whole_reg <= '0;
                        mark_rv_reg    <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Hold the beat, slot contents and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg   <= s_kind;
            handle_reg <= s_surface_handle;
            key_reg    <= s_surface_key;
            busy_reg   <= s_capture_busy;
            exact_reg  <= s_rect_exact;
            wl_reg     <= s_wr_left;
            wt_reg     <= s_wr_top;
            wr_reg     <= s_wr_right;
            wb_reg     <= s_wr_bottom;
        end
        if (state_reg == ST_MSCAN) begin
            if (m_used_s && cmp_hit && !mhit_reg) begin
                midx_reg <= midx_s;
            end
            if (!m_used_s && !mfree_reg) begin
                fidx_reg <= midx_s;
            end
        end
        if (exec_fire) begin
            if (reg_go && !t_full) begin
                target_handle_mem[tcount_reg[TIDX_W-1:0]] <= handle_reg;
                target_key_mem[tcount_reg[TIDX_W-1:0]]    <= key_reg;
            end
            if (take_go && slot_ok) begin
                mark_key_mem[slot] <= key_reg;
                if (mw_go && exact_reg && !w_empty) begin
                    mark_l_mem[slot] <= n_l;
                    mark_t_mem[slot] <= n_t;
                    mark_r_mem[slot] <= n_r;
                    mark_b_mem[slot] <= n_b;
                end
            end
            m_region_reg  <= res_region;
            m_l_reg       <= res_l;
            m_t_reg       <= res_t;
            m_r_reg       <= res_r;
            m_b_reg       <= res_b;
            m_pending_reg <= res_pending;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_region     = m_region_reg;
    assign m_out_left   = m_l_reg;
    assign m_out_top    = m_t_reg;
    assign m_out_right  = m_r_reg;
    assign m_out_bottom = m_b_reg;
    assign m_pending    = m_pending_reg;

    // Target count stays within the list
    a_tcount_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(tcount_reg) <= TARGET_SLOTS)
        else $error("target count beyond list size");

    // Tracking every surface only after the list filled
    a_track_full: assert property (@(posedge aclk) disable iff (!aresetn)
        track_reg |-> (32'(tcount_reg) == TARGET_SLOTS))
        else $error("track-every set with target list not full");

    // A reset operation clears all tracker state
    a_reset_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && kind_reg == KIND_RESET) |=>
        (tcount_reg == '0 && !ovf_reg && !track_reg && mark_whole_reg == '0 &&
         mark_rv_reg == '0))
        else $error("reset operation left state behind");

    // A needed mark with no free slot raises overflow
    a_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && take_go && !slot_ok) |=> ovf_reg)
        else $error("missed overflow on full mark table");

    // A query answer carries no consume answer
    a_one_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_pending_reg) |-> (m_region_reg == REGION_NONE))
        else $error("query result carries a region");

endmodule
